### src/ots_pkg.sv
package ots_pkg;

  localparam int unsigned CURRENT_WIDTH = 10;
  localparam int unsigned THR_WIDTH     = 10;
  localparam int unsigned CNT_WIDTH     = 16;
  localparam int unsigned NUM_CNT       = 7;
  localparam int unsigned NUM_REGS      = 7;
  localparam int unsigned ADDR_WIDTH    = 5;
  localparam int unsigned DATA_WIDTH    = 32;

  typedef logic [CURRENT_WIDTH-1:0] current_t;
  typedef logic [THR_WIDTH-1:0]     thr_t;
  typedef logic [CNT_WIDTH-1:0]     cnt_t;
  typedef logic [NUM_CNT-1:0]       flags_t;

  typedef enum logic [1:0] {
    CMD_EVAL  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    REG_NOM_FULL   = 3'd0,
    REG_HIGH_FULL  = 3'd1,
    REG_NOM_HALF   = 3'd2,
    REG_HIGH_HALF  = 3'd3,
    REG_HARD_BUDG  = 3'd4,
    REG_SOFT_BUDG  = 3'd5,
    REG_DRAIN_STEP = 3'd6
  } reg_idx_e;

  // Flag layout shared by the alarm and condition words.
  localparam int unsigned BIT_FULL_HARD = 0;
  localparam int unsigned BIT_FULL_MILD = 1;
  localparam int unsigned BIT_HALF_HARD = 2;
  localparam int unsigned BIT_HALF_MILD = 3;
  localparam int unsigned BIT_CONT1     = 4;
  localparam int unsigned BIT_CONT2     = 5;
  localparam int unsigned BIT_SUPPLY    = 6;

  // Counters that run against the hard budget.
  localparam flags_t HARD_CNT_MASK = flags_t'(7'b0000101);

  localparam thr_t RST_NOM_FULL   = thr_t'(367);
  localparam thr_t RST_HIGH_FULL  = thr_t'(400);
  localparam thr_t RST_NOM_HALF   = thr_t'(183);
  localparam thr_t RST_HIGH_HALF  = thr_t'(200);
  localparam cnt_t RST_HARD_BUDG  = cnt_t'(55000);
  localparam cnt_t RST_SOFT_BUDG  = cnt_t'(60);
  localparam cnt_t RST_DRAIN_STEP = cnt_t'(360);

endpackage

### src/overcurrent_trip_supervisor_top.sv
// Latency: a result beat is valid in the cycle after its input beat is accepted.
// Throughput: one item per cycle; the state registers double as the result register,
// so a new item is taken whenever the result is taken in the same cycle or none waits.
// Reset (rst_ni, asynchronous, active low): thresholds and budgets go to their defaults,
// flags and peaks clear, and every fault counter is loaded with its budget.
module overcurrent_trip_supervisor_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [1:0]                           command_i,
  input  logic [ots_pkg::CURRENT_WIDTH-1:0]    current_full_a_i,
  input  logic [ots_pkg::CURRENT_WIDTH-1:0]    current_full_b_i,
  input  logic [ots_pkg::CURRENT_WIDTH-1:0]    current_full_c_i,
  input  logic [ots_pkg::CURRENT_WIDTH-1:0]    current_half_a_i,
  input  logic [ots_pkg::CURRENT_WIDTH-1:0]    current_half_b_i,
  input  logic [ots_pkg::CURRENT_WIDTH-1:0]    current_half_c_i,
  input  logic                                 first_drive_i,
  input  logic                                 second_drive_i,
  input  logic                                 first_sense_i,
  input  logic                                 second_sense_i,
  input  logic                                 supply_good_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [ots_pkg::NUM_CNT-1:0]          alarm_flags_o,
  output logic [ots_pkg::NUM_CNT-1:0]          condition_flags_o,
  output logic [ots_pkg::CURRENT_WIDTH-1:0]    peak_full_o,
  output logic [ots_pkg::CURRENT_WIDTH-1:0]    peak_half_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ots_pkg::ADDR_WIDTH-1:0]       paddr,
  input  logic [ots_pkg::DATA_WIDTH-1:0]       pwdata,
  output logic [ots_pkg::DATA_WIDTH-1:0]       prdata,
  output logic                                 pready
);

  ots_pkg::thr_t     nom_full_q, high_full_q, nom_half_q, high_half_q;
  ots_pkg::cnt_t     hard_budg_q, soft_budg_q, drain_step_q;

  ots_pkg::flags_t   cond_q, cond_d;
  ots_pkg::flags_t   alarm_q, alarm_d;
  ots_pkg::current_t peak_full_q, peak_full_d;
  ots_pkg::current_t peak_half_q, peak_half_d;
  ots_pkg::cnt_t     cnt_q [ots_pkg::NUM_CNT];
  ots_pkg::cnt_t     cnt_d [ots_pkg::NUM_CNT];
  logic              out_valid_q;

  logic              in_acc;
  logic              cfg_wr;
  ots_pkg::reg_idx_e cfg_idx;
  ots_pkg::cmd_e     cmd;

  ots_pkg::cnt_t     budget   [ots_pkg::NUM_CNT];
  ots_pkg::cnt_t     cnt_dec  [ots_pkg::NUM_CNT];
  ots_pkg::cnt_t     cnt_inc  [ots_pkg::NUM_CNT];
  ots_pkg::cnt_t     cnt_drn  [ots_pkg::NUM_CNT];
  ots_pkg::current_t pk_full, pk_half;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign cmd        = ots_pkg::cmd_e'(command_i);

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = ots_pkg::reg_idx_e'(paddr[4:2]);

  // Configuration registers and read-back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nom_full_q   <= ots_pkg::RST_NOM_FULL;
      high_full_q  <= ots_pkg::RST_HIGH_FULL;
      nom_half_q   <= ots_pkg::RST_NOM_HALF;
      high_half_q  <= ots_pkg::RST_HIGH_HALF;
      hard_budg_q  <= ots_pkg::RST_HARD_BUDG;
      soft_budg_q  <= ots_pkg::RST_SOFT_BUDG;
      drain_step_q <= ots_pkg::RST_DRAIN_STEP;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        ots_pkg::REG_NOM_FULL:   nom_full_q   <= pwdata[ots_pkg::THR_WIDTH-1:0];
        ots_pkg::REG_HIGH_FULL:  high_full_q  <= pwdata[ots_pkg::THR_WIDTH-1:0];
        ots_pkg::REG_NOM_HALF:   nom_half_q   <= pwdata[ots_pkg::THR_WIDTH-1:0];
        ots_pkg::REG_HIGH_HALF:  high_half_q  <= pwdata[ots_pkg::THR_WIDTH-1:0];
        ots_pkg::REG_HARD_BUDG:  hard_budg_q  <= pwdata[ots_pkg::CNT_WIDTH-1:0];
        ots_pkg::REG_SOFT_BUDG:  soft_budg_q  <= pwdata[ots_pkg::CNT_WIDTH-1:0];
        ots_pkg::REG_DRAIN_STEP: drain_step_q <= pwdata[ots_pkg::CNT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      ots_pkg::REG_NOM_FULL:   prdata = ots_pkg::DATA_WIDTH'(nom_full_q);
      ots_pkg::REG_HIGH_FULL:  prdata = ots_pkg::DATA_WIDTH'(high_full_q);
      ots_pkg::REG_NOM_HALF:   prdata = ots_pkg::DATA_WIDTH'(nom_half_q);
      ots_pkg::REG_HIGH_HALF:  prdata = ots_pkg::DATA_WIDTH'(high_half_q);
      ots_pkg::REG_HARD_BUDG:  prdata = ots_pkg::DATA_WIDTH'(hard_budg_q);
      ots_pkg::REG_SOFT_BUDG:  prdata = ots_pkg::DATA_WIDTH'(soft_budg_q);
      ots_pkg::REG_DRAIN_STEP: prdata = ots_pkg::DATA_WIDTH'(drain_step_q);
      default:                 prdata = '0;
    endcase
  end

  // Group peaks.
  always_comb begin
    pk_full = current_full_a_i;
    if (current_full_b_i > pk_full) pk_full = current_full_b_i;
    if (current_full_c_i > pk_full) pk_full = current_full_c_i;
    pk_half = current_half_a_i;
    if (current_half_b_i > pk_half) pk_half = current_half_b_i;
    if (current_half_c_i > pk_half) pk_half = current_half_c_i;
  end

  // Per-counter candidate values, all independent of each other.
  always_comb begin
    for (int i = 0; i < ots_pkg::NUM_CNT; i++) begin
      budget[i]  = ots_pkg::HARD_CNT_MASK[i] ? hard_budg_q : soft_budg_q;
      cnt_dec[i] = (cnt_q[i] == '0) ? cnt_q[i] : cnt_q[i] - 1'b1;
      // A counter above a lowered budget is left where it is.
      cnt_inc[i] = (cnt_q[i] < budget[i]) ? cnt_q[i] + 1'b1 : cnt_q[i];
      cnt_drn[i] = (cnt_q[i] >= drain_step_q) ? cnt_q[i] - drain_step_q : '0;
    end
  end

  always_comb begin
    cond_d      = cond_q;
    alarm_d     = alarm_q;
    peak_full_d = peak_full_q;
    peak_half_d = peak_half_q;
    cnt_d       = cnt_q;
    if (in_acc) begin
      unique case (cmd)
        ots_pkg::CMD_EVAL: begin
          peak_full_d = pk_full;
          peak_half_d = pk_half;
          // Above the high threshold the mild bit keeps its old value.
          if (pk_full > high_full_q) begin
            cond_d[ots_pkg::BIT_FULL_HARD] = 1'b1;
          end else if (pk_full > nom_full_q) begin
            cond_d[ots_pkg::BIT_FULL_HARD] = 1'b0;
            cond_d[ots_pkg::BIT_FULL_MILD] = 1'b1;
          end else begin
            cond_d[ots_pkg::BIT_FULL_HARD] = 1'b0;
            cond_d[ots_pkg::BIT_FULL_MILD] = 1'b0;
          end
          if (pk_half > high_half_q) begin
            cond_d[ots_pkg::BIT_HALF_HARD] = 1'b1;
          end else if (pk_half > nom_half_q) begin
            cond_d[ots_pkg::BIT_HALF_HARD] = 1'b0;
            cond_d[ots_pkg::BIT_HALF_MILD] = 1'b1;
          end else begin
            cond_d[ots_pkg::BIT_HALF_HARD] = 1'b0;
            cond_d[ots_pkg::BIT_HALF_MILD] = 1'b0;
          end
          cond_d[ots_pkg::BIT_CONT1]  = (first_drive_i == first_sense_i);
          cond_d[ots_pkg::BIT_CONT2]  = (second_drive_i == second_sense_i);
          cond_d[ots_pkg::BIT_SUPPLY] = !supply_good_i;
          for (int i = 0; i < ots_pkg::NUM_CNT; i++) begin
            if (cnt_q[i] == '0) alarm_d[i] = 1'b1;
          end
          // Overload alarms release once their counter is back at full.
          for (int i = 0; i < 4; i++) begin
            if (cnt_q[i] == budget[i]) alarm_d[i] = 1'b0;
          end
        end
        ots_pkg::CMD_TICK: begin
          for (int g = 0; g < 2; g++) begin
            if (cond_q[2*g]) begin
              cnt_d[2*g]   = cnt_drn[2*g];
              cnt_d[2*g+1] = cnt_dec[2*g+1];
            end else if (cond_q[2*g+1]) begin
              cnt_d[2*g+1] = cnt_dec[2*g+1];
            end else begin
              cnt_d[2*g]   = cnt_inc[2*g];
              cnt_d[2*g+1] = cnt_inc[2*g+1];
            end
          end
          for (int i = 4; i < ots_pkg::NUM_CNT; i++) begin
            cnt_d[i] = cond_q[i] ? cnt_dec[i] : cnt_inc[i];
          end
        end
        ots_pkg::CMD_CLEAR: begin
          cond_d  = '0;
          alarm_d = '0;
          cnt_d   = budget;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cond_q      <= '0;
      alarm_q     <= '0;
      peak_full_q <= '0;
      peak_half_q <= '0;
      for (int i = 0; i < ots_pkg::NUM_CNT; i++) begin
        cnt_q[i] <= ots_pkg::HARD_CNT_MASK[i] ? ots_pkg::RST_HARD_BUDG
                                              : ots_pkg::RST_SOFT_BUDG;
      end
    end else begin
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      cond_q      <= cond_d;
      alarm_q     <= alarm_d;
      peak_full_q <= peak_full_d;
      peak_half_q <= peak_half_d;
      cnt_q       <= cnt_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign alarm_flags_o     = alarm_q;
  assign condition_flags_o = cond_q;
  assign peak_full_o       = peak_full_q;
  assign peak_half_o       = peak_half_q;

endmodule

### src/ots_checker.sv
module ots_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic [1:0]                        command_i,
  input logic [ots_pkg::CURRENT_WIDTH-1:0] current_full_a_i,
  input logic [ots_pkg::CURRENT_WIDTH-1:0] current_full_b_i,
  input logic [ots_pkg::CURRENT_WIDTH-1:0] current_full_c_i,
  input logic                              supply_good_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [ots_pkg::NUM_CNT-1:0]       alarm_flags_o,
  input logic [ots_pkg::NUM_CNT-1:0]       condition_flags_o,
  input logic [ots_pkg::CURRENT_WIDTH-1:0] peak_full_o
);

  logic acc;
  assign acc = in_valid_i && in_ready_o;

  // A result beat that is not taken keeps its flags.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(alarm_flags_o)
      && $stable(condition_flags_o))
    else $error("stalled result beat changed");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && command_i == ots_pkg::CMD_CLEAR |=>
      out_valid_o && alarm_flags_o == '0 && condition_flags_o == '0)
    else $error("clear beat did not zero the flag words");

  a_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && command_i == ots_pkg::CMD_EVAL |=>
      peak_full_o >= $past(current_full_a_i) && peak_full_o >= $past(current_full_b_i)
      && peak_full_o >= $past(current_full_c_i)
      && (peak_full_o == $past(current_full_a_i) || peak_full_o == $past(current_full_b_i)
          || peak_full_o == $past(current_full_c_i)))
    else $error("full group peak is not the largest phase current");

  a_supply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && command_i == ots_pkg::CMD_EVAL |=>
      condition_flags_o[ots_pkg::BIT_SUPPLY] == !$past(supply_good_i))
    else $error("supply condition bit does not follow supply_good");

endmodule

bind overcurrent_trip_supervisor_top ots_checker u_ots_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .command_i         (command_i),
  .current_full_a_i  (current_full_a_i),
  .current_full_b_i  (current_full_b_i),
  .current_full_c_i  (current_full_c_i),
  .supply_good_i     (supply_good_i),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .alarm_flags_o     (alarm_flags_o),
  .condition_flags_o (condition_flags_o),
  .peak_full_o       (peak_full_o)
);

### dv/tb_overcurrent_trip_supervisor_top.sv
`timescale 1ns / 100ps

import ots_pkg::*;

typedef struct {
  logic [1:0] command;
  current_t   full_a;
  current_t   full_b;
  current_t   full_c;
  current_t   half_a;
  current_t   half_b;
  current_t   half_c;
  logic       first_drive;
  logic       second_drive;
  logic       first_sense;
  logic       second_sense;
  logic       supply_good;
} trip_item_t;

typedef struct {
  flags_t   alarm;
  flags_t   cond;
  current_t peak_full;
  current_t peak_half;
} trip_status_t;

class trip_scoreboard;
  thr_t         nom_full;
  thr_t         high_full;
  thr_t         nom_half;
  thr_t         high_half;
  cnt_t         hard_budget;
  cnt_t         soft_budget;
  cnt_t         drain_step;
  flags_t       cond_bits;
  flags_t       alarm_bits;
  cnt_t         fault_cnt[NUM_CNT];
  current_t     peak_full;
  current_t     peak_half;
  trip_status_t expected_status_q[$];
  int unsigned  error_count;

  function new();
    nom_full    = RST_NOM_FULL;
    high_full   = RST_HIGH_FULL;
    nom_half    = RST_NOM_HALF;
    high_half   = RST_HIGH_HALF;
    hard_budget = RST_HARD_BUDG;
    soft_budget = RST_SOFT_BUDG;
    drain_step  = RST_DRAIN_STEP;
    cond_bits   = '0;
    alarm_bits  = '0;
    peak_full   = '0;
    peak_half   = '0;
    error_count = 0;
    refill_counters();
  endfunction

  function cnt_t budget(int unsigned i);
    return HARD_CNT_MASK[i] ? hard_budget : soft_budget;
  endfunction

  function void refill_counters();
    for (int i = 0; i < NUM_CNT; i++) begin
      fault_cnt[i] = budget(i);
    end
  endfunction

  function void write_reg(reg_idx_e idx, logic [DATA_WIDTH-1:0] value);
    case (idx)
      REG_NOM_FULL:   nom_full    = value[THR_WIDTH-1:0];
      REG_HIGH_FULL:  high_full   = value[THR_WIDTH-1:0];
      REG_NOM_HALF:   nom_half    = value[THR_WIDTH-1:0];
      REG_HIGH_HALF:  high_half   = value[THR_WIDTH-1:0];
      REG_HARD_BUDG:  hard_budget = value[CNT_WIDTH-1:0];
      REG_SOFT_BUDG:  soft_budget = value[CNT_WIDTH-1:0];
      REG_DRAIN_STEP: drain_step  = value[CNT_WIDTH-1:0];
      default: ;
    endcase
  endfunction

  function logic [DATA_WIDTH-1:0] reg_value(reg_idx_e idx);
    case (idx)
      REG_NOM_FULL:   return DATA_WIDTH'(nom_full);
      REG_HIGH_FULL:  return DATA_WIDTH'(high_full);
      REG_NOM_HALF:   return DATA_WIDTH'(nom_half);
      REG_HIGH_HALF:  return DATA_WIDTH'(high_half);
      REG_HARD_BUDG:  return DATA_WIDTH'(hard_budget);
      REG_SOFT_BUDG:  return DATA_WIDTH'(soft_budget);
      REG_DRAIN_STEP: return DATA_WIDTH'(drain_step);
      default:        return '0;
    endcase
  endfunction

  function current_t peak_of(current_t a, current_t b, current_t c);
    current_t m;
    m = a;
    if (b > m) m = b;
    if (c > m) m = c;
    return m;
  endfunction

  // A hard overload keeps the mild bit as it was; a mild one drops the hard bit.
  function flags_t grade_group(flags_t c, current_t pk, thr_t nom, thr_t hi,
                               int unsigned hard_bit, int unsigned mild_bit);
    if (pk > hi) begin
      c[hard_bit] = 1'b1;
    end else if (pk > nom) begin
      c[mild_bit] = 1'b1;
      c[hard_bit] = 1'b0;
    end else begin
      c[hard_bit] = 1'b0;
      c[mild_bit] = 1'b0;
    end
    return c;
  endfunction

  function void count_down(int unsigned i);
    if (fault_cnt[i] != '0) fault_cnt[i] = fault_cnt[i] - 1'b1;
  endfunction

  // A counter left above a lowered budget is neither raised nor pulled down.
  function void count_up(int unsigned i);
    if (fault_cnt[i] < budget(i)) fault_cnt[i] = fault_cnt[i] + 1'b1;
  endfunction

  // Counter i tracks condition bit i, so the flag positions index the counters.
  function void tick_group(int unsigned hard_i, int unsigned mild_i);
    if (cond_bits[hard_i]) begin
      fault_cnt[hard_i] = (fault_cnt[hard_i] >= drain_step) ?
                          fault_cnt[hard_i] - drain_step : '0;
      count_down(mild_i);
    end else if (cond_bits[mild_i]) begin
      count_down(mild_i);
    end else begin
      count_up(hard_i);
      count_up(mild_i);
    end
  endfunction

  function void predict_status(trip_item_t it);
    trip_status_t st;
    case (it.command)
      CMD_EVAL: begin
        peak_full = peak_of(it.full_a, it.full_b, it.full_c);
        peak_half = peak_of(it.half_a, it.half_b, it.half_c);
        cond_bits = grade_group(cond_bits, peak_full, nom_full, high_full,
                                BIT_FULL_HARD, BIT_FULL_MILD);
        cond_bits = grade_group(cond_bits, peak_half, nom_half, high_half,
                                BIT_HALF_HARD, BIT_HALF_MILD);
        cond_bits[BIT_CONT1]  = (it.first_drive == it.first_sense);
        cond_bits[BIT_CONT2]  = (it.second_drive == it.second_sense);
        cond_bits[BIT_SUPPLY] = !it.supply_good;
        for (int i = 0; i < NUM_CNT; i++) begin
          if (fault_cnt[i] == '0) alarm_bits[i] = 1'b1;
        end
        // Overload alarms release once their counter is back at full, even
        // when that same counter has just set them.
        for (int i = BIT_FULL_HARD; i <= BIT_HALF_MILD; i++) begin
          if (fault_cnt[i] == budget(i)) alarm_bits[i] = 1'b0;
        end
      end
      CMD_TICK: begin
        tick_group(BIT_FULL_HARD, BIT_FULL_MILD);
        tick_group(BIT_HALF_HARD, BIT_HALF_MILD);
        for (int i = BIT_CONT1; i <= BIT_SUPPLY; i++) begin
          if (cond_bits[i]) begin
            count_down(i);
          end else begin
            count_up(i);
          end
        end
      end
      CMD_CLEAR: begin
        alarm_bits = '0;
        cond_bits  = '0;
        refill_counters();
      end
      default: ;
    endcase
    st.alarm     = alarm_bits;
    st.cond      = cond_bits;
    st.peak_full = peak_full;
    st.peak_half = peak_half;
    expected_status_q.push_back(st);
  endfunction

  task report(string msg);
    error_count++;
    $display("[%0t] ERROR: %s", $time, msg);
  endtask

  task check_status(trip_status_t got);
    trip_status_t want;
    if (expected_status_q.size() == 0) begin
      report($sformatf("status beat with nothing outstanding (alarm %h cond %h)",
                       got.alarm, got.cond));
      return;
    end
    want = expected_status_q.pop_front();
    if (got.alarm !== want.alarm)
      report($sformatf("alarm_flags %h, expected %h", got.alarm, want.alarm));
    if (got.cond !== want.cond)
      report($sformatf("condition_flags %h, expected %h", got.cond, want.cond));
    if (got.peak_full !== want.peak_full)
      report($sformatf("peak_full %0d, expected %0d", got.peak_full, want.peak_full));
    if (got.peak_half !== want.peak_half)
      report($sformatf("peak_half %0d, expected %0d", got.peak_half, want.peak_half));
  endtask
endclass

module tb_overcurrent_trip_supervisor_top;

  localparam logic [1:0]  CMD_UNUSED     = 2'd3;
  localparam int unsigned CUR_MAX        = (1 << CURRENT_WIDTH) - 1;
  localparam int unsigned REG_STRIDE     = 4;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 4;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [1:0]            command_i;
  current_t              current_full_a_i;
  current_t              current_full_b_i;
  current_t              current_full_c_i;
  current_t              current_half_a_i;
  current_t              current_half_b_i;
  current_t              current_half_c_i;
  logic                  first_drive_i;
  logic                  second_drive_i;
  logic                  first_sense_i;
  logic                  second_sense_i;
  logic                  supply_good_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  flags_t                alarm_flags_o;
  flags_t                condition_flags_o;
  current_t              peak_full_o;
  current_t              peak_half_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_WIDTH-1:0] paddr;
  logic [DATA_WIDTH-1:0] pwdata;
  logic [DATA_WIDTH-1:0] prdata;
  logic                  pready;

  trip_scoreboard trip_sb = new();
  int unsigned    send_idle_pct  = 0;
  int unsigned    recv_stall_pct = 0;
  int unsigned    idle_cycles    = 0;

  overcurrent_trip_supervisor_top i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .command_i         (command_i),
    .current_full_a_i  (current_full_a_i),
    .current_full_b_i  (current_full_b_i),
    .current_full_c_i  (current_full_c_i),
    .current_half_a_i  (current_half_a_i),
    .current_half_b_i  (current_half_b_i),
    .current_half_c_i  (current_half_c_i),
    .first_drive_i     (first_drive_i),
    .second_drive_i    (second_drive_i),
    .first_sense_i     (first_sense_i),
    .second_sense_i    (second_sense_i),
    .supply_good_i     (supply_good_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .alarm_flags_o     (alarm_flags_o),
    .condition_flags_o (condition_flags_o),
    .peak_full_o       (peak_full_o),
    .peak_half_o       (peak_half_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i = ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : status_mon
    trip_status_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.alarm     = alarm_flags_o;
      got.cond      = condition_flags_o;
      got.peak_full = peak_full_o;
      got.peak_half = peak_half_o;
      trip_sb.check_status(got);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic trip_item_t make_eval(int unsigned fa, int unsigned fb, int unsigned fc,
                                           int unsigned ha, int unsigned hb, int unsigned hc,
                                           logic [3:0] contact, logic supply);
    trip_item_t it;
    it.command = CMD_EVAL;
    it.full_a  = current_t'(fa);
    it.full_b  = current_t'(fb);
    it.full_c  = current_t'(fc);
    it.half_a  = current_t'(ha);
    it.half_b  = current_t'(hb);
    it.half_c  = current_t'(hc);
    {it.first_drive, it.second_drive, it.first_sense, it.second_sense} = contact;
    it.supply_good = supply;
    return it;
  endfunction

  // Payload fields ride along with random content even where they are ignored.
  function automatic trip_item_t make_cmd_item(logic [1:0] cmd);
    trip_item_t it;
    it.command = cmd;
    it.full_a  = current_t'($urandom);
    it.full_b  = current_t'($urandom);
    it.full_c  = current_t'($urandom);
    it.half_a  = current_t'($urandom);
    it.half_b  = current_t'($urandom);
    it.half_c  = current_t'($urandom);
    {it.first_drive, it.second_drive, it.first_sense, it.second_sense,
     it.supply_good} = 5'($urandom);
    return it;
  endfunction

  function automatic current_t pick_current(thr_t nom, thr_t hi, bit quiet);
    int v;
    if (quiet) return current_t'($urandom_range(0, nom));
    case ($urandom_range(0, 5))
      0:       v = 0;
      1:       v = CUR_MAX;
      2:       v = int'(nom) + int'($urandom_range(0, 4)) - 2;
      3:       v = int'(hi) + int'($urandom_range(0, 4)) - 2;
      default: v = int'($urandom_range(0, CUR_MAX));
    endcase
    if (v < 0) v = 0;
    if (v > int'(CUR_MAX)) v = CUR_MAX;
    return current_t'(v);
  endfunction

  function automatic trip_item_t rand_eval();
    trip_item_t it;
    bit         quiet_full;
    bit         quiet_half;
    quiet_full      = ($urandom_range(0, 99) < 45);
    quiet_half      = ($urandom_range(0, 99) < 45);
    it.command      = CMD_EVAL;
    it.full_a       = pick_current(trip_sb.nom_full, trip_sb.high_full, quiet_full);
    it.full_b       = pick_current(trip_sb.nom_full, trip_sb.high_full, quiet_full);
    it.full_c       = pick_current(trip_sb.nom_full, trip_sb.high_full, quiet_full);
    it.half_a       = pick_current(trip_sb.nom_half, trip_sb.high_half, quiet_half);
    it.half_b       = pick_current(trip_sb.nom_half, trip_sb.high_half, quiet_half);
    it.half_c       = pick_current(trip_sb.nom_half, trip_sb.high_half, quiet_half);
    it.first_drive  = 1'($urandom);
    it.second_drive = 1'($urandom);
    it.first_sense  = ($urandom_range(0, 9) == 0) ? it.first_drive : !it.first_drive;
    it.second_sense = ($urandom_range(0, 9) == 0) ? it.second_drive : !it.second_drive;
    it.supply_good  = ($urandom_range(0, 9) != 0);
    return it;
  endfunction

  task automatic send_item(trip_item_t it);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    command_i        = it.command;
    current_full_a_i = it.full_a;
    current_full_b_i = it.full_b;
    current_full_c_i = it.full_c;
    current_half_a_i = it.half_a;
    current_half_b_i = it.half_b;
    current_half_c_i = it.half_c;
    first_drive_i    = it.first_drive;
    second_drive_i   = it.second_drive;
    first_sense_i    = it.first_sense;
    second_sense_i   = it.second_sense;
    supply_good_i    = it.supply_good;
    in_valid_i       = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    trip_sb.predict_status(it);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (trip_sb.expected_status_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_write(reg_idx_e idx, logic [DATA_WIDTH-1:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ADDR_WIDTH'(REG_STRIDE * int'(idx));
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    trip_sb.write_reg(idx, value);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_registers();
    reg_idx_e idx;
    for (int i = 0; i < NUM_REGS; i++) begin
      idx = reg_idx_e'(i);
      @(negedge clk_i);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = ADDR_WIDTH'(REG_STRIDE * i);
      @(negedge clk_i);
      penable = 1'b1;
      do @(posedge clk_i); while (!pready);
      if (prdata !== trip_sb.reg_value(idx))
        trip_sb.report($sformatf("register %s reads %h, expected %h", idx.name(), prdata,
                                 trip_sb.reg_value(idx)));
      @(negedge clk_i);
      psel    = 1'b0;
      penable = 1'b0;
    end
  endtask

  task automatic set_config(int unsigned nom_f, int unsigned high_f, int unsigned nom_h,
                            int unsigned high_h, int unsigned hard_b, int unsigned soft_b,
                            int unsigned step);
    apb_write(REG_NOM_FULL, nom_f);
    apb_write(REG_HIGH_FULL, high_f);
    apb_write(REG_NOM_HALF, nom_h);
    apb_write(REG_HIGH_HALF, high_h);
    apb_write(REG_HARD_BUDG, hard_b);
    apb_write(REG_SOFT_BUDG, soft_b);
    apb_write(REG_DRAIN_STEP, step);
    check_registers();
  endtask

  task automatic set_idling(idle_mode_e mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 54; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 54; end
      default:       begin send_idle_pct = 21; recv_stall_pct = 21; end
    endcase
  endtask

  // Contact pattern is {first_drive, second_drive, first_sense, second_sense}.
  task automatic run_directed();
    send_item(make_eval(0, 0, 0, 0, 0, 0, 4'b1001, 1'b1));
    send_item(make_cmd_item(CMD_TICK));
    send_item(make_eval(CUR_MAX, 0, 0, 0, 0, CUR_MAX, 4'b0000, 1'b0));
    send_item(make_cmd_item(CMD_TICK));
    send_item(make_cmd_item(CMD_TICK));
    send_item(make_eval(0, 0, 0, 0, 0, 0, 4'b1001, 1'b1));
    // Peaks sitting exactly on the nominal threshold count as no overload.
    send_item(make_eval(367, 366, 0, 183, 0, 0, 4'b1000, 1'b1));
    // Peaks exactly on the high threshold are only a mild overload.
    send_item(make_eval(0, 368, 400, 0, 184, 200, 4'b0001, 1'b1));
    send_item(make_cmd_item(CMD_TICK));
    send_item(make_eval(0, 0, 401, 201, 0, 0, 4'b1100, 1'b1));
    send_item(make_cmd_item(CMD_TICK));
    send_item(make_eval(10'h2AA, 10'h155, 10'h3FF, 10'h155, 10'h2AA, 0, 4'b1111, 1'b0));
    send_item(make_cmd_item(CMD_TICK));
    send_item(make_cmd_item(CMD_UNUSED));
    send_item(make_cmd_item(CMD_CLEAR));
    send_item(make_cmd_item(CMD_UNUSED));
    send_item(make_eval(CUR_MAX, CUR_MAX, CUR_MAX, CUR_MAX, CUR_MAX, CUR_MAX,
                        4'b1010, 1'b1));
    send_item(make_cmd_item(CMD_TICK));
    send_item(make_eval(10'h155, 10'h2AA, 0, 10'h3FF, 10'h155, 10'h2AA, 4'b0110, 1'b0));
    send_item(make_cmd_item(CMD_CLEAR));
    send_item(make_eval(0, 0, 0, 0, 0, 0, 4'b1100, 1'b1));
  endtask

  // Bursts of one evaluate followed by a run of ticks, so that conditions
  // persist long enough to drain counters into their alarms.
  task automatic run_random(int unsigned n_items);
    int unsigned sent;
    int unsigned n_ticks;
    trip_item_t  it;
    bit          paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      if (!paused && sent >= n_items / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      send_item(rand_eval());
      sent++;
      n_ticks = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 8);
      repeat (n_ticks) begin
        send_item(make_cmd_item(CMD_TICK));
        sent++;
      end
      case ($urandom_range(0, 19))
        0: begin
          send_item(make_cmd_item(CMD_CLEAR));
          sent++;
        end
        1: send_item(make_cmd_item(CMD_UNUSED));
        2: begin
          it = make_cmd_item(2'($urandom));
          send_item(it);
          if (it.command != CMD_UNUSED) sent++;
        end
        default: ;
      endcase
    end
  endtask

  initial begin
    int unsigned lvl;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    command_i        = CMD_EVAL;
    current_full_a_i = '0;
    current_full_b_i = '0;
    current_full_c_i = '0;
    current_half_a_i = '0;
    current_half_b_i = '0;
    current_half_c_i = '0;
    first_drive_i    = 1'b0;
    second_drive_i   = 1'b0;
    first_sense_i    = 1'b0;
    second_sense_i   = 1'b0;
    supply_good_i    = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    check_registers();
    set_idling(IDLE_NONE);
    run_directed();
    run_random(150);

    // Inverted half-group thresholds: any nonzero half current is a hard overload.
    wait_drained();
    set_config(0, CUR_MAX, CUR_MAX, 0, 300, 5, 100);
    set_idling(IDLE_SENDER);
    run_random(125);

    // Budgets of one and no hard drain at all.
    wait_drained();
    lvl = $urandom_range(100, 600);
    set_config(lvl, lvl + $urandom_range(0, 300), lvl / 2, lvl / 2 + $urandom_range(0, 150),
               1, 1, 0);
    set_idling(IDLE_RECEIVER);
    run_random(125);

    wait_drained();
    set_config(CUR_MAX, CUR_MAX, 0, 0, 65535, 65535, 65535);
    set_idling(IDLE_BOTH);
    run_random(125);

    // Budgets drop below those of the previous phase, so counters it left higher stay above them.
    wait_drained();
    lvl = $urandom_range(50, 800);
    set_config(lvl, lvl + $urandom_range(0, 100), lvl / 3, lvl / 3 + $urandom_range(0, 60),
               20, 3, 7);
    set_idling(IDLE_SENDER);
    run_random(125);

    // Zero budgets: counters that reach zero stay there, and an overload alarm sets and releases together.
    wait_drained();
    set_config($urandom_range(0, CUR_MAX), $urandom_range(0, CUR_MAX),
               $urandom_range(0, CUR_MAX), $urandom_range(0, CUR_MAX), 0, 0, 1);
    set_idling(IDLE_RECEIVER);
    run_random(125);

    wait_drained();
    set_config($urandom_range(0, CUR_MAX), $urandom_range(0, CUR_MAX),
               $urandom_range(0, CUR_MAX), $urandom_range(0, CUR_MAX),
               $urandom_range(1, 4000), $urandom_range(1, 40), $urandom_range(0, 500));
    set_idling(IDLE_BOTH);
    run_random(125);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (trip_sb.expected_status_q.size() != 0)
      trip_sb.report($sformatf("%0d status beats never arrived",
                               trip_sb.expected_status_q.size()));
    if (trip_sb.error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
src/ots_pkg.sv
src/overcurrent_trip_supervisor_top.sv
src/ots_checker.sv
dv/tb_overcurrent_trip_supervisor_top.sv
